### src/swss_pkg.sv
`timescale 1ns / 1ps

package swss_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned StepW  = 10;
  localparam int unsigned CountW = 3;
  localparam int unsigned TimerW = 12;
  localparam int unsigned RegIdxW = 3;

  localparam int unsigned NumWays = 4;

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [StepW-1:0]  step_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [TimerW-1:0] timer_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  localparam count_t MaxWaypoints = count_t'(NumWays);

  typedef enum logic [1:0] {
    PhMove = 2'd0,
    PhWait = 2'd1,
    PhFire = 2'd2,
    PhRest = 2'd3
  } phase_e;

  // register indexes on the config channel
  localparam reg_idx_t RegPosStart  = 3'd0;
  localparam reg_idx_t RegPosWay1   = 3'd1;
  localparam reg_idx_t RegPosWay2   = 3'd2;
  localparam reg_idx_t RegPosWay3   = 3'd3;
  localparam reg_idx_t RegPosWay4   = 3'd4;
  localparam reg_idx_t RegSlewStep  = 3'd5;
  localparam reg_idx_t RegUpdateGap = 3'd6;

  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  localparam timer_t WaitTicks = 12'd200;
  localparam timer_t FireTicks = 12'd3000;
  localparam timer_t RestTicks = 12'd1000;

  localparam pos_t TrigIdle = 12'd1000;
  localparam pos_t TrigLive = 12'd2200;
  localparam pos_t TrigDry  = 12'd1100;

  localparam pos_t  RstPosStart  = 12'd1500;
  localparam pos_t  RstPosWay1   = 12'd1000;
  localparam pos_t  RstPosWay2   = 12'd1300;
  localparam pos_t  RstPosWay3   = 12'd1700;
  localparam pos_t  RstPosWay4   = 12'd2000;
  localparam step_t RstSlewStep  = 10'd50;
  localparam step_t RstUpdateGap = 10'd50;

  typedef struct packed {
    pos_t                     pos_start;
    logic [NumWays-1:0][PosW-1:0] pos_way;
    step_t                    slew_step;
    step_t                    update_gap;
  } cfg_t;

  typedef struct packed {
    pos_t   current_pos;
    pos_t   target_pos;
    step_t  gap_counter;
    count_t served_count;
    count_t run_count;
    logic   dry_flag;
    phase_e phase;
    timer_t phase_timer;
  } state_t;

  typedef struct packed {
    logic   req_type;
    count_t way_count;
    logic   dry_run;
  } req_t;

  typedef struct packed {
    pos_t       servo_pos;
    pos_t       trigger_width;
    logic [1:0] phase_out;
    count_t     way_index;
  } res_t;

endpackage

### src/swss_if.sv
`timescale 1ns / 1ps

interface swss_in_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  swss_pkg::count_t      way_count;
  logic                  dry_run;

  modport source (output valid, output req_type, output way_count, output dry_run,
                  input ready);
  modport sink (input valid, input req_type, input way_count, input dry_run,
                output ready);
endinterface

interface swss_out_if;
  logic                  valid;
  logic                  ready;
  swss_pkg::pos_t        servo_pos;
  swss_pkg::pos_t        trigger_width;
  logic [1:0]            phase_out;
  swss_pkg::count_t      way_index;

  modport source (output valid, output servo_pos, output trigger_width,
                  output phase_out, output way_index, input ready);
  modport sink (input valid, input servo_pos, input trigger_width,
                input phase_out, input way_index, output ready);
endinterface

interface swss_cfg_if;
  logic                  valid;
  logic                  ready;
  swss_pkg::reg_idx_t    reg_index;
  swss_pkg::pos_t        wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### src/swss_update.sv
`timescale 1ns / 1ps

module swss_update (
  input  swss_pkg::cfg_t   cfg_i,
  input  swss_pkg::state_t state_i,
  input  swss_pkg::req_t   req_i,
  output swss_pkg::state_t state_o,
  output swss_pkg::res_t   res_o
);
  import swss_pkg::*;

  logic [PosW:0] up_sum;
  logic [PosW:0] down_lim;
  logic          arrive;
  timer_t        timer_dec;

  assign up_sum    = {1'b0, state_i.current_pos} + {{(PosW+1-StepW){1'b0}}, cfg_i.slew_step};
  assign down_lim  = {1'b0, state_i.target_pos} + {{(PosW+1-StepW){1'b0}}, cfg_i.slew_step};
  assign timer_dec = (state_i.phase_timer != '0) ? state_i.phase_timer - timer_t'(1)
                                                 : state_i.phase_timer;

  // next state
  always_comb begin
    state_o = state_i;
    arrive  = 1'b0;
    if (req_i.req_type == ReqStart) begin
      state_o.run_count    = (req_i.way_count > MaxWaypoints) ? MaxWaypoints
                                                              : req_i.way_count;
      state_o.served_count = '0;
      state_o.target_pos   = cfg_i.pos_way[0];
      state_o.dry_flag     = req_i.dry_run;
      state_o.phase        = PhMove;
      state_o.phase_timer  = '0;
    end else begin
      unique case (state_i.phase)
        PhMove: begin
          if (state_i.gap_counter >= cfg_i.update_gap) begin
            state_o.gap_counter = '0;
            if (state_i.target_pos > state_i.current_pos) begin
              if (up_sum >= {1'b0, state_i.target_pos}) begin
                state_o.current_pos = state_i.target_pos;
                arrive = 1'b1;
              end else begin
                state_o.current_pos = up_sum[PosW-1:0];
              end
            end else if (state_i.target_pos < state_i.current_pos) begin
              // clamp at target rather than wrapping below zero
              if ({1'b0, state_i.current_pos} <= down_lim) begin
                state_o.current_pos = state_i.target_pos;
                arrive = 1'b1;
              end else begin
                state_o.current_pos = state_i.current_pos
                                      - {{(PosW-StepW){1'b0}}, cfg_i.slew_step};
              end
            end
            if (arrive && state_i.run_count != '0) begin
              state_o.served_count = state_i.served_count + count_t'(1);
              state_o.phase        = PhWait;
              state_o.phase_timer  = WaitTicks;
            end
          end else begin
            state_o.gap_counter = state_i.gap_counter + step_t'(1);
          end
        end
        default: begin
          if (state_i.gap_counter < cfg_i.update_gap) begin
            state_o.gap_counter = state_i.gap_counter + step_t'(1);
          end
          state_o.phase_timer = timer_dec;
          if (timer_dec == '0) begin
            unique case (state_i.phase)
              PhWait: begin
                state_o.phase       = PhFire;
                state_o.phase_timer = FireTicks;
              end
              PhFire: begin
                state_o.phase       = PhRest;
                state_o.phase_timer = RestTicks;
              end
              default: begin
                state_o.phase = PhMove;
                if (state_i.served_count < state_i.run_count &&
                    state_i.served_count < count_t'(NumWays)) begin
                  state_o.target_pos = cfg_i.pos_way[state_i.served_count[1:0]];
                end else begin
                  // run done, head home
                  state_o.served_count = '0;
                  state_o.run_count    = '0;
                  state_o.target_pos   = cfg_i.pos_start;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // result word from the updated state
  always_comb begin
    res_o.servo_pos     = state_o.current_pos;
    res_o.phase_out     = state_o.phase;
    res_o.way_index     = state_o.served_count;
    if (state_o.phase == PhFire) begin
      res_o.trigger_width = state_o.dry_flag ? TrigDry : TrigLive;
    end else begin
      res_o.trigger_width = TrigIdle;
    end
  end

endmodule

### src/servo_waypoint_slew_sequencer_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// in_i      in   valid/ready   req_type, way_count, dry_run
// out_o     out  valid/ready   servo_pos, trigger_width, phase_out, way_index
// cfg_i     in   valid/ready   reg_index, wdata (always ready)
//
// one word a cycle sustained while the output is not stalled: an input register feeds the update logic, which
// writes the result register and the sequencer state in the same cycle.
// the result is valid once the word held in the input register advances into the result register.
// while a result stalls, the input register still takes one more word.
// reset loads the register defaults and puts the servo at the home position.

module servo_waypoint_slew_sequencer_core (
  input logic       clk_i,
  input logic       rst_ni,
  swss_in_if.sink   in_i,
  swss_out_if.source out_o,
  swss_cfg_if.sink  cfg_i
);
  import swss_pkg::*;

  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;
  req_t   req_q;
  logic   req_valid_q;
  res_t   res_q;
  res_t   res_d;
  logic   out_valid_q;
  logic   adv;

  assign adv         = req_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !req_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_start  <= RstPosStart;
      cfg_q.pos_way[0] <= RstPosWay1;
      cfg_q.pos_way[1] <= RstPosWay2;
      cfg_q.pos_way[2] <= RstPosWay3;
      cfg_q.pos_way[3] <= RstPosWay4;
      cfg_q.slew_step  <= RstSlewStep;
      cfg_q.update_gap <= RstUpdateGap;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        RegPosStart:  cfg_q.pos_start  <= cfg_i.wdata;
        RegPosWay1:   cfg_q.pos_way[0] <= cfg_i.wdata;
        RegPosWay2:   cfg_q.pos_way[1] <= cfg_i.wdata;
        RegPosWay3:   cfg_q.pos_way[2] <= cfg_i.wdata;
        RegPosWay4:   cfg_q.pos_way[3] <= cfg_i.wdata;
        RegSlewStep:  cfg_q.slew_step  <= cfg_i.wdata[StepW-1:0];
        RegUpdateGap: cfg_q.update_gap <= cfg_i.wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  swss_update u_update (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.current_pos  <= RstPosStart;
      state_q.target_pos   <= RstPosStart;
      state_q.gap_counter  <= '0;
      state_q.served_count <= '0;
      state_q.run_count    <= '0;
      state_q.dry_flag     <= 1'b0;
      state_q.phase        <= PhMove;
      state_q.phase_timer  <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        req_valid_q <= 1'b1;
      end else if (adv) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q.req_type  <= in_i.req_type;
      req_q.way_count <= in_i.way_count;
      req_q.dry_run   <= in_i.dry_run;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.servo_pos     = res_q.servo_pos;
  assign out_o.trigger_width = res_q.trigger_width;
  assign out_o.phase_out     = res_q.phase_out;
  assign out_o.way_index     = res_q.way_index;

  a_timed_phase_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != PhMove |-> state_q.run_count != '0)
    else $error("timed phase with no active run");

  a_served_within_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.served_count <= state_q.run_count && state_q.run_count <= MaxWaypoints)
    else $error("served count beyond run count");

  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != PhMove |-> state_q.phase_timer != '0)
    else $error("timed phase with expired timer");

  a_trigger_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.phase_out != PhFire |-> res_q.trigger_width == TrigIdle)
    else $error("trigger active outside trigger hold");

endmodule

### tb/sv/tb_servo_waypoint_slew_sequencer_core.sv
`timescale 1ns / 1ps

module tb_servo_waypoint_slew_sequencer_core;
  import swss_pkg::*;

  // index with no register behind it, writes are dropped
  localparam reg_idx_t RegUnmapped = 3'd7;

  class waypoint_tracker;
    pos_t       home;
    pos_t       ways [NumWays];
    step_t      step;
    step_t      gap;
    pos_t       cur;
    pos_t       tgt;
    step_t      gap_cnt;
    count_t     served;
    count_t     run_cnt;
    logic       dry_f;
    phase_e     phase;
    timer_t     ptimer;
    int unsigned errors;
    res_t       pending_results [$];

    function new();
      home    = RstPosStart;
      ways[0] = RstPosWay1;
      ways[1] = RstPosWay2;
      ways[2] = RstPosWay3;
      ways[3] = RstPosWay4;
      step    = RstSlewStep;
      gap     = RstUpdateGap;
      cur     = RstPosStart;
      tgt     = RstPosStart;
      gap_cnt = '0;
      served  = '0;
      run_cnt = '0;
      dry_f   = 1'b0;
      phase   = PhMove;
      ptimer  = '0;
      errors  = 0;
    endfunction

    task report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(input reg_idx_t idx, input pos_t word);
      case (idx)
        RegPosStart:  home = word;
        RegPosWay1:   ways[0] = word;
        RegPosWay2:   ways[1] = word;
        RegPosWay3:   ways[2] = word;
        RegPosWay4:   ways[3] = word;
        RegSlewStep:  step = word[StepW-1:0];
        RegUpdateGap: gap = word[StepW-1:0];
        default: ;
      endcase
    endfunction

    function bit drained();
      return pending_results.size() == 0;
    endfunction

    // nothing more will happen until the next start word
    function bit parked();
      return phase == PhMove && cur == tgt;
    endfunction

    function void arrive();
      cur = tgt;
      if (run_cnt == 0) return;
      served = served + 1'b1;
      phase  = PhWait;
      ptimer = WaitTicks;
    endfunction

    function void slew();
      int unsigned c, t, s;
      c = cur;
      t = tgt;
      s = step;
      if (t > c) begin
        if (c + s >= t) arrive();
        else cur = pos_t'(c + s);
      end else if (t < c) begin
        // clamp at the target rather than wrapping below zero
        if (c <= t + s) arrive();
        else cur = pos_t'(c - s);
      end
    endfunction

    function void advance_tick();
      if (phase == PhMove) begin
        if (gap_cnt >= gap) begin
          gap_cnt = '0;
          slew();
        end else begin
          gap_cnt = gap_cnt + 1'b1;
        end
        return;
      end
      if (gap_cnt < gap) gap_cnt = gap_cnt + 1'b1;
      if (ptimer > 0) ptimer = ptimer - 1'b1;
      if (ptimer != 0) return;
      case (phase)
        PhWait: begin
          phase  = PhFire;
          ptimer = FireTicks;
        end
        PhFire: begin
          phase  = PhRest;
          ptimer = RestTicks;
        end
        default: begin
          phase  = PhMove;
          ptimer = '0;
          if (served < run_cnt && served < MaxWaypoints) begin
            tgt = ways[served[1:0]];
          end else begin
            served  = '0;
            run_cnt = '0;
            tgt     = home;
          end
        end
      endcase
    endfunction

    function void take_request(input logic kind, input count_t cnt, input logic dry);
      res_t exp;
      if (kind == ReqStart) begin
        run_cnt = (cnt > MaxWaypoints) ? MaxWaypoints : cnt;
        served  = '0;
        tgt     = ways[0];
        dry_f   = dry;
        phase   = PhMove;
        ptimer  = '0;
      end else begin
        advance_tick();
      end
      exp.servo_pos     = cur;
      exp.trigger_width = (phase == PhFire) ? (dry_f ? TrigDry : TrigLive) : TrigIdle;
      exp.phase_out     = phase;
      exp.way_index     = served;
      pending_results.push_back(exp);
    endfunction

    task match_result(input pos_t pos, input pos_t trig, input logic [1:0] ph,
                      input count_t idx);
      res_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with none expected, pos %0d", pos));
        return;
      end
      exp = pending_results.pop_front();
      if (pos !== exp.servo_pos)
        report($sformatf("servo_pos got %0d want %0d", pos, exp.servo_pos));
      if (trig !== exp.trigger_width)
        report($sformatf("trigger_width got %0d want %0d", trig, exp.trigger_width));
      if (ph !== exp.phase_out)
        report($sformatf("phase_out got %0d want %0d", ph, exp.phase_out));
      if (idx !== exp.way_index)
        report($sformatf("way_index got %0d want %0d", idx, exp.way_index));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   feed_calm;
  bit   sink_calm;

  waypoint_tracker track = new();

  swss_in_if  in_if ();
  swss_out_if out_if ();
  swss_cfg_if cfg_if ();

  servo_waypoint_slew_sequencer_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic int unsigned pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic pos_t pick_pos();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 12'hfff : 12'h000;
    return pos_t'($urandom_range(0, 4095));
  endfunction

  function automatic count_t pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 3'd0;
    if (r <= 5) return 3'd1;
    if (r <= 9) return 3'd2;
    if (r <= 12) return 3'd3;
    if (r <= 16) return 3'd4;
    return count_t'($urandom_range(5, 7));
  endfunction

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        track.match_result(out_if.servo_pos, out_if.trigger_width, out_if.phase_out,
                           out_if.way_index);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!sink_calm && $urandom_range(0, 99) < 15) begin
        out_if.ready <= 1'b0;
        stall_left = pick_stall() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic kind, input count_t cnt, input logic dry);
    int unsigned pause;
    pause = feed_calm ? 0 : pick_pause();
    if (pause > 0) begin
      in_if.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.req_type  <= kind;
    in_if.way_count <= cnt;
    in_if.dry_run   <= dry;
    do @(posedge clk); while (!in_if.ready);
    track.take_request(kind, cnt, dry);
  endtask

  task automatic push_tick();
    push_req(ReqTick, count_t'($urandom), 1'($urandom));
  endtask

  // hold the input back until every result word is home
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (!track.drained());
    repeat (4) @(posedge clk);
  endtask

  // leaves valid high so back to back writes stay clean
  task automatic write_reg(input reg_idx_t idx, input pos_t word);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= word;
    do @(posedge clk); while (!cfg_if.ready);
    track.write_reg(idx, word);
  endtask

  task automatic program_regs(input pos_t home, input pos_t ways [NumWays],
                              input pos_t step_word, input pos_t gap_word);
    write_reg(RegPosStart, home);
    write_reg(RegPosWay1, ways[0]);
    write_reg(RegPosWay2, ways[1]);
    write_reg(RegPosWay3, ways[2]);
    write_reg(RegPosWay4, ways[3]);
    write_reg(RegSlewStep, step_word);
    write_reg(RegUpdateGap, gap_word);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic reprogram_random();
    pos_t  ways [NumWays];
    step_t s;
    step_t g;
    int unsigned r;
    foreach (ways[i]) ways[i] = pick_pos();
    r = $urandom_range(0, 99);
    if (r < 5) s = 10'd1;
    else if (r < 15) s = 10'd1023;
    else s = step_t'($urandom_range(64, 1023));
    // a long update gap only with a big step, so legs stay short
    if (s >= 512 && $urandom_range(0, 4) == 0) g = 10'd1023;
    else if (s == 1) g = 10'd0;
    else g = step_t'($urandom_range(0, 6));
    program_regs(pick_pos(), ways, {2'($urandom), s}, {2'($urandom), g});
  endtask

  initial begin : stimulus
    pos_t        ways [NumWays];
    int unsigned fed;
    int unsigned cutoff;
    int unsigned n;
    bit          first;

    in_if.valid      <= 1'b0;
    in_if.req_type   <= ReqTick;
    in_if.way_count  <= '0;
    in_if.dry_run    <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= RegPosStart;
    cfg_if.wdata     <= '0;
    rst_n            <= 1'b0;
    feed_calm = 1'b0;
    sink_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // register defaults straight out of reset
    push_tick();
    push_req(ReqStart, 3'd2, 1'b0);
    push_req(ReqTick, 3'd7, 1'b1);
    settle();

    // extremes: full-scale waypoints, biggest step, update on every tick
    ways = '{12'h000, 12'hfff, 12'h000, 12'hfff};
    write_reg(RegUnmapped, 12'hfff);
    program_regs(12'hfff, ways, 12'd1023, 12'd0);
    push_tick();
    push_tick();
    push_req(ReqStart, 3'd7, 1'b1);
    push_tick();
    push_tick();
    push_tick();
    push_req(ReqStart, 3'd0, 1'b0);
    push_tick();
    push_req(ReqStart, 3'd4, 1'b0);
    push_tick();
    push_req(ReqStart, 3'd5, 1'b1);
    push_req(ReqStart, 3'd6, 1'b0);
    push_tick();
    settle();

    // step and gap words with only the upper bits set mask down to zero
    foreach (ways[i]) ways[i] = pick_pos();
    program_regs(pick_pos(), ways, 12'hc00, 12'h400);
    push_req(ReqStart, 3'd3, 1'b1);
    repeat (6) push_tick();
    settle();

    fed   = 0;
    first = 1'b1;
    while (fed < 1450) begin
      if (first || $urandom_range(0, 99) < 35) begin
        settle();
        reprogram_random();
      end
      first = 1'b0;
      feed_calm = ($urandom_range(0, 5) == 0);
      sink_calm = ($urandom_range(0, 5) == 0);
      push_req(ReqStart, pick_count(), 1'($urandom));
      fed++;
      // a quarter of the runs get cut short early, the rest get a much longer tick budget
      cutoff = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(150, 400);
      n = 0;
      while (n < cutoff && !track.parked()) begin
        push_tick();
        n++;
        fed++;
      end
      repeat ($urandom_range(0, 20)) begin
        push_tick();
        fed++;
      end
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (!track.drained());
    repeat (8) @(posedge clk);
    if (track.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
